>>> design/sexp_pkg.sv
// ----------------------------------------------------------------------------
// Sensor exposure timing control package
// Widths, register codes, state and operation types, command and status words.
// ----------------------------------------------------------------------------
package sexp_pkg;

  localparam int unsigned VAL_W      = 40;
  localparam int unsigned MUL_A_W    = 40;
  localparam int unsigned MUL_B_W    = 32;
  localparam int unsigned PROD_W     = 72;
  localparam int unsigned DIVR_W     = 56;
  localparam int unsigned WORD_W     = 24;
  localparam int unsigned LINE_W     = 20;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam int unsigned MUL_STEPS  = 32;
  localparam int unsigned MUL_CNT_W  = 5;
  localparam int unsigned DIV_STEPS  = 72;
  localparam int unsigned DIV_CNT_W  = 7;

  localparam logic [LINE_W-1:0]  MIN_FRAME    = 20'd2250;
  localparam logic [LINE_W-1:0]  MAX_FRAME    = 20'hFFFFF;
  localparam logic [LINE_W-1:0]  MIN_LINES    = 20'd4;
  localparam logic [LINE_W-1:0]  MIN_SHUTTER  = 20'd8;
  localparam logic [MUL_B_W-1:0] GAIN_MAX     = 32'd100;
  localparam logic [MUL_B_W-1:0] GAIN_DB      = 32'd30;

  localparam logic [ADDR_W-1:0]  ADDR_HOLD    = 16'h3001;
  localparam logic [ADDR_W-1:0]  ADDR_FRAME   = 16'h3024;
  localparam logic [ADDR_W-1:0]  ADDR_SHUTTER = 16'h3050;
  localparam logic [ADDR_W-1:0]  ADDR_GAIN    = 16'h3090;

  typedef enum logic [1:0] {
    OP_GAIN  = 2'd0,
    OP_EXPO  = 2'd1,
    OP_FRAME = 2'd2,
    OP_HOLD  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PCLK       = 3'd0,
    CFG_LINE_LEN   = 3'd1,
    CFG_RATE_SCALE = 3'd2,
    CFG_EXP_SCALE  = 3'd3,
    CFG_GAIN_SCALE = 3'd4,
    CFG_GAIN_FLOOR = 3'd5,
    CFG_GAIN_CEIL  = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_DSTART,
    ST_DIV,
    ST_FIN,
    ST_EMIT,
    ST_REEXP
  } state_e;

  typedef struct packed {
    logic load;
    logic reexp;
    logic set_reject;
    logic set_hold;
    logic mul_start;
    logic mul_sel;
    logic store_x;
    logic store_y;
    logic div_start;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic hold;
    logic mul_done;
    logic div_done;
    logic emit_last;
    logic more;
  } status_t;

endpackage

>>> design/sexp_if.sv
// ----------------------------------------------------------------------------
// Sensor exposure timing control channels
// Request channel and register write channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sexp_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [sexp_pkg::VAL_W-1:0]  req_value;

  modport source (output valid, output req_type, output req_value, input ready);
  modport sink   (input valid, input req_type, input req_value, output ready);
endinterface

interface sexp_res_if;
  logic                         valid;
  logic                         ready;
  logic [sexp_pkg::ADDR_W-1:0]  reg_addr;
  logic [sexp_pkg::BYTE_W-1:0]  reg_byte;
  logic                         status;
  logic                         last;

  modport source (output valid, output reg_addr, output reg_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input reg_addr, input reg_byte, input status,
                  input last, output ready);
endinterface

>>> design/sexp_mul.sv
// ----------------------------------------------------------------------------
// Sequential multiplier
// Shift-and-add, one bit of the B operand per cycle.
// ----------------------------------------------------------------------------
module sexp_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sexp_pkg::MUL_A_W-1:0]  a_i,
  input  logic [sexp_pkg::MUL_B_W-1:0]  b_i,
  output logic                          done_o,
  output logic [sexp_pkg::PROD_W-1:0]   prod_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [sexp_pkg::MUL_CNT_W-1:0]   cnt_q, cnt_d;
  logic [sexp_pkg::PROD_W-1:0]      acc_q, acc_d;
  logic [sexp_pkg::PROD_W-1:0]      a_q, a_d;
  logic [sexp_pkg::MUL_B_W-1:0]     b_q, b_d;

  // Load operands or advance one bit
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      a_d    = {{(sexp_pkg::PROD_W - sexp_pkg::MUL_A_W){1'b0}}, a_i};
      b_d    = b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = {a_q[sexp_pkg::PROD_W-2:0], 1'b0};
      b_d   = {1'b0, b_q[sexp_pkg::MUL_B_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == sexp_pkg::MUL_CNT_W'(sexp_pkg::MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> design/sexp_div.sv
// ----------------------------------------------------------------------------
// Sequential divider
// Restoring division, one quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module sexp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sexp_pkg::PROD_W-1:0]   num_i,
  input  logic [sexp_pkg::DIVR_W-1:0]   den_i,
  output logic                          done_o,
  output logic [sexp_pkg::PROD_W-1:0]   quo_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [sexp_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [sexp_pkg::DIVR_W-1:0]      rem_q, rem_d;
  logic [sexp_pkg::PROD_W-1:0]      quo_q, quo_d;
  logic [sexp_pkg::DIVR_W-1:0]      den_q, den_d;
  logic [sexp_pkg::DIVR_W:0]        trial;
  logic [sexp_pkg::DIVR_W:0]        diff;
  logic                             take;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial  = {rem_q, quo_q[sexp_pkg::PROD_W-1]};
    diff   = trial - {1'b0, den_q};
    take   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = take ? diff[sexp_pkg::DIVR_W-1:0] : trial[sexp_pkg::DIVR_W-1:0];
      quo_d = {quo_q[sexp_pkg::PROD_W-2:0], take};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == sexp_pkg::DIV_CNT_W'(sexp_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> design/sexp_dp.sv
// ----------------------------------------------------------------------------
// Sensor exposure timing datapath
// Settings, frame and exposure state, operand selection, arithmetic units
// and the output word register.
// ----------------------------------------------------------------------------
module sexp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sexp_pkg::cmd_t                    cmd_i,
  output sexp_pkg::status_t                 status_o,
  input  logic [1:0]                        req_type_i,
  input  logic [sexp_pkg::VAL_W-1:0]        req_value_i,
  input  logic                              cfg_we_i,
  input  logic [sexp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sexp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [sexp_pkg::ADDR_W-1:0]       reg_addr_o,
  output logic [sexp_pkg::BYTE_W-1:0]       reg_byte_o,
  output logic                              status_bit_o,
  output logic                              last_o
);

  // Settings
  logic [31:0]                     pclk_q;
  logic [15:0]                     line_len_q;
  logic [19:0]                     rate_scale_q;
  logic [19:0]                     exp_scale_q;
  logic [19:0]                     gain_scale_q;
  logic [sexp_pkg::VAL_W-1:0]      gain_floor_q;
  logic [sexp_pkg::VAL_W-1:0]      gain_ceil_q;

  // Sensor state
  logic [sexp_pkg::LINE_W-1:0]     frame_lines_q, frame_lines_d;
  logic [sexp_pkg::VAL_W-1:0]      last_exp_q, last_exp_d;

  // Request and working registers
  sexp_pkg::op_e                   op_q;
  logic [sexp_pkg::VAL_W-1:0]      val_q;
  logic [sexp_pkg::VAL_W-1:0]      val_load;
  logic [sexp_pkg::PROD_W-1:0]     x_q;
  logic [sexp_pkg::DIVR_W-1:0]     y_q;

  // Write batch
  logic [sexp_pkg::WORD_W-1:0]     word_q, word_d;
  logic [sexp_pkg::ADDR_W-1:0]     base_q, base_d;
  logic [1:0]                      last_idx_q, last_idx_d;
  logic [1:0]                      k_q;
  logic                            rej_q, rej_d;
  logic                            more_q, more_d;

  // Output word
  logic [sexp_pkg::ADDR_W-1:0]     out_addr_q;
  logic [sexp_pkg::BYTE_W-1:0]     out_byte_q;
  logic                            out_rej_q;
  logic                            out_last_q;
  logic [sexp_pkg::BYTE_W-1:0]     cur_byte;

  // Arithmetic units
  logic [sexp_pkg::MUL_A_W-1:0]    mul_a;
  logic [sexp_pkg::MUL_B_W-1:0]    mul_b;
  logic                            mul_done;
  logic [sexp_pkg::PROD_W-1:0]     prod;
  logic                            div_done;
  logic [sexp_pkg::PROD_W-1:0]     quo;

  // Result shaping
  logic [6:0]                      gain_val;
  logic [sexp_pkg::LINE_W-1:0]     frame_val;
  logic [sexp_pkg::LINE_W-1:0]     max_lines;
  logic [sexp_pkg::LINE_W-1:0]     lines;
  logic [sexp_pkg::LINE_W-1:0]     shutter;
  logic                            reject;

  sexp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  sexp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (x_q),
    .den_i   (y_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Write settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pclk_q       <= '0;
      line_len_q   <= '0;
      rate_scale_q <= 20'd1000000;
      exp_scale_q  <= 20'd1000000;
      gain_scale_q <= 20'd1;
      gain_floor_q <= '0;
      gain_ceil_q  <= 40'd30;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sexp_pkg::CFG_PCLK:       pclk_q       <= cfg_data_i[31:0];
        sexp_pkg::CFG_LINE_LEN:   line_len_q   <= cfg_data_i[15:0];
        sexp_pkg::CFG_RATE_SCALE: rate_scale_q <= cfg_data_i[19:0];
        sexp_pkg::CFG_EXP_SCALE:  exp_scale_q  <= cfg_data_i[19:0];
        sexp_pkg::CFG_GAIN_SCALE: gain_scale_q <= cfg_data_i[19:0];
        sexp_pkg::CFG_GAIN_FLOOR: gain_floor_q <= cfg_data_i;
        sexp_pkg::CFG_GAIN_CEIL:  gain_ceil_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp gain requests to the limits, floor first
  always_comb begin
    val_load = req_value_i;
    if (req_type_i == sexp_pkg::OP_GAIN) begin
      priority if (req_value_i < gain_floor_q) begin
        val_load = gain_floor_q;
      end else if (req_value_i > gain_ceil_q) begin
        val_load = gain_ceil_q;
      end else begin
        val_load = req_value_i;
      end
    end
  end

  // Pick multiplier operands for the first and second product
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_q)
      sexp_pkg::OP_GAIN: begin
        mul_a = cmd_i.mul_sel ? {20'd0, gain_scale_q} : val_q;
        mul_b = cmd_i.mul_sel ? sexp_pkg::GAIN_DB : sexp_pkg::GAIN_MAX;
      end
      sexp_pkg::OP_FRAME: begin
        mul_a = cmd_i.mul_sel ? val_q : {8'd0, pclk_q};
        mul_b = cmd_i.mul_sel ? {16'd0, line_len_q} : {12'd0, rate_scale_q};
      end
      sexp_pkg::OP_EXPO: begin
        mul_a = cmd_i.mul_sel ? {20'd0, exp_scale_q} : val_q;
        mul_b = cmd_i.mul_sel ? {16'd0, line_len_q} : pclk_q;
      end
      sexp_pkg::OP_HOLD: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Reject checks on zero divisors and bad settings
  always_comb begin
    reject = 1'b0;
    unique case (op_q)
      sexp_pkg::OP_GAIN:  reject = (gain_scale_q == '0);
      sexp_pkg::OP_EXPO:  reject = (pclk_q == '0) || (exp_scale_q == '0) ||
                                   (line_len_q == '0);
      sexp_pkg::OP_FRAME: reject = (val_q == '0) || (line_len_q == '0);
      sexp_pkg::OP_HOLD:  reject = 1'b0;
    endcase
  end

  // Shape the quotient into the register value
  always_comb begin
    gain_val  = (quo > sexp_pkg::PROD_W'(sexp_pkg::GAIN_MAX)) ?
                sexp_pkg::GAIN_MAX[6:0] : quo[6:0];
    frame_val = quo[sexp_pkg::LINE_W-1:0];
    if (quo < sexp_pkg::PROD_W'(sexp_pkg::MIN_FRAME)) begin
      frame_val = sexp_pkg::MIN_FRAME;
    end else if (quo > sexp_pkg::PROD_W'(sexp_pkg::MAX_FRAME)) begin
      frame_val = sexp_pkg::MAX_FRAME;
    end
    max_lines = frame_lines_q - sexp_pkg::MIN_SHUTTER;
    lines     = quo[sexp_pkg::LINE_W-1:0];
    if (quo < sexp_pkg::PROD_W'(sexp_pkg::MIN_LINES)) begin
      lines = sexp_pkg::MIN_LINES;
    end else if (quo > sexp_pkg::PROD_W'(max_lines)) begin
      lines = max_lines;
    end
    shutter = frame_lines_q - lines;
  end

  // Set up the next batch of writes
  always_comb begin
    word_d        = word_q;
    base_d        = base_q;
    last_idx_d    = last_idx_q;
    rej_d         = rej_q;
    more_d        = more_q;
    frame_lines_d = frame_lines_q;
    last_exp_d    = last_exp_q;
    if (cmd_i.load || cmd_i.reexp) begin
      more_d = 1'b0;
    end
    if (cmd_i.set_reject) begin
      word_d     = '0;
      base_d     = '0;
      last_idx_d = 2'd0;
      rej_d      = 1'b1;
      more_d     = 1'b0;
    end
    if (cmd_i.set_hold) begin
      word_d     = {{(sexp_pkg::WORD_W-1){1'b0}}, (val_q != '0)};
      base_d     = sexp_pkg::ADDR_HOLD;
      last_idx_d = 2'd0;
      rej_d      = 1'b0;
      more_d     = 1'b0;
    end
    if (cmd_i.finish) begin
      rej_d = 1'b0;
      unique case (op_q)
        sexp_pkg::OP_GAIN: begin
          word_d     = {{(sexp_pkg::WORD_W-7){1'b0}}, gain_val};
          base_d     = sexp_pkg::ADDR_GAIN;
          last_idx_d = 2'd1;
          more_d     = 1'b0;
        end
        sexp_pkg::OP_FRAME: begin
          word_d        = {{(sexp_pkg::WORD_W-sexp_pkg::LINE_W){1'b0}}, frame_val};
          base_d        = sexp_pkg::ADDR_FRAME;
          last_idx_d    = 2'd2;
          frame_lines_d = frame_val;
          more_d        = (last_exp_q != '0);
        end
        sexp_pkg::OP_EXPO: begin
          word_d     = {{(sexp_pkg::WORD_W-sexp_pkg::LINE_W){1'b0}}, shutter};
          base_d     = sexp_pkg::ADDR_SHUTTER;
          last_idx_d = 2'd2;
          last_exp_d = val_q;
          more_d     = 1'b0;
        end
        sexp_pkg::OP_HOLD: begin
          more_d = 1'b0;
        end
      endcase
    end
  end

  // Byte of the batch word for the current index
  always_comb begin
    unique case (k_q)
      2'd0:    cur_byte = word_q[7:0];
      2'd1:    cur_byte = word_q[15:8];
      default: cur_byte = word_q[23:16];
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_lines_q <= sexp_pkg::MIN_FRAME;
      last_exp_q    <= '0;
      op_q          <= sexp_pkg::OP_GAIN;
      last_idx_q    <= '0;
      k_q           <= '0;
      rej_q         <= 1'b0;
      more_q        <= 1'b0;
    end else begin
      frame_lines_q <= frame_lines_d;
      last_exp_q    <= last_exp_d;
      last_idx_q    <= last_idx_d;
      rej_q         <= rej_d;
      more_q        <= more_d;
      if (cmd_i.load) begin
        op_q <= sexp_pkg::op_e'(req_type_i);
      end else if (cmd_i.reexp) begin
        op_q <= sexp_pkg::OP_EXPO;
      end
      if (cmd_i.set_reject || cmd_i.set_hold || cmd_i.finish) begin
        k_q <= '0;
      end else if (cmd_i.out_load) begin
        k_q <= k_q + 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= val_load;
    end else if (cmd_i.reexp) begin
      val_q <= last_exp_q;
    end
    if (cmd_i.store_x && mul_done) begin
      x_q <= prod;
    end
    if (cmd_i.store_y && mul_done) begin
      y_q <= prod[sexp_pkg::DIVR_W-1:0];
    end
    word_q <= word_d;
    base_q <= base_d;
    if (cmd_i.out_load) begin
      out_addr_q <= base_q + {{(sexp_pkg::ADDR_W-2){1'b0}}, k_q};
      out_byte_q <= cur_byte;
      out_rej_q  <= rej_q;
      out_last_q <= (k_q == last_idx_q) && !more_q;
    end
  end

  assign status_o.reject    = reject;
  assign status_o.hold      = (op_q == sexp_pkg::OP_HOLD);
  assign status_o.mul_done  = mul_done;
  assign status_o.div_done  = div_done;
  assign status_o.emit_last = (k_q == last_idx_q);
  assign status_o.more      = more_q;

  assign reg_addr_o   = out_addr_q;
  assign reg_byte_o   = out_byte_q;
  assign status_bit_o = out_rej_q;
  assign last_o       = out_last_q;

endmodule

>>> design/sexp_ctrl.sv
// ----------------------------------------------------------------------------
// Sensor exposure timing controller
// Sequences check, two products, the division and the byte writes.
// ----------------------------------------------------------------------------
module sexp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  sexp_pkg::status_t  status_i,
  output sexp_pkg::cmd_t     cmd_o
);

  sexp_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sexp_pkg::ST_IDLE:   if (in_valid_i) state_d = sexp_pkg::ST_CHECK;
      sexp_pkg::ST_CHECK: begin
        if (status_i.reject || status_i.hold) begin
          state_d = sexp_pkg::ST_EMIT;
        end else begin
          state_d = sexp_pkg::ST_MUL1;
        end
      end
      sexp_pkg::ST_MUL1:   if (status_i.mul_done) state_d = sexp_pkg::ST_MUL2;
      sexp_pkg::ST_MUL2:   if (status_i.mul_done) state_d = sexp_pkg::ST_DSTART;
      sexp_pkg::ST_DSTART: state_d = sexp_pkg::ST_DIV;
      sexp_pkg::ST_DIV:    if (status_i.div_done) state_d = sexp_pkg::ST_FIN;
      sexp_pkg::ST_FIN:    state_d = sexp_pkg::ST_EMIT;
      sexp_pkg::ST_EMIT: begin
        if (out_free && status_i.emit_last) begin
          state_d = status_i.more ? sexp_pkg::ST_REEXP : sexp_pkg::ST_IDLE;
        end
      end
      sexp_pkg::ST_REEXP:  state_d = sexp_pkg::ST_CHECK;
      default:             state_d = sexp_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sexp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sexp_pkg::ST_CHECK: begin
        priority if (status_i.reject) begin
          cmd_o.set_reject = 1'b1;
        end else if (status_i.hold) begin
          cmd_o.set_hold = 1'b1;
        end else begin
          cmd_o.mul_start = 1'b1;
        end
      end
      sexp_pkg::ST_MUL1: begin
        cmd_o.store_x   = 1'b1;
        cmd_o.mul_sel   = status_i.mul_done;
        cmd_o.mul_start = status_i.mul_done;
      end
      sexp_pkg::ST_MUL2: begin
        cmd_o.store_y = 1'b1;
        cmd_o.mul_sel = 1'b1;
      end
      sexp_pkg::ST_DSTART: cmd_o.div_start = 1'b1;
      sexp_pkg::ST_DIV:    ;
      sexp_pkg::ST_FIN:    cmd_o.finish = 1'b1;
      sexp_pkg::ST_EMIT:   cmd_o.out_load = out_free;
      sexp_pkg::ST_REEXP:  cmd_o.reexp = 1'b1;
      default:             ;
    endcase
  end

  // Hold the output word until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/sensor_exposure_timing_control.sv
// Gain, exposure and frame rate requests pass through two products and a division
// before the first write word, then give one word per cycle while the output is taken;
// a frame rate request that re-derives the exposure runs this sequence twice.
// Group hold and rejected requests skip the arithmetic and give their single word.
// One request at a time; the next is taken while the last word waits at the output.
// Reset (asynchronous, active low) restores settings, frame lines 2250, exposure 0.
// ----------------------------------------------------------------------------
// Sensor exposure timing control
// Turns gain, exposure, frame rate and group hold requests into sensor
// register byte writes.
// ----------------------------------------------------------------------------
module sensor_exposure_timing_control (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sexp_req_if.sink                          req,
  sexp_res_if.source                        res,
  input  logic                              cfg_we_i,
  input  logic [sexp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sexp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  sexp_pkg::cmd_t    cmd;
  sexp_pkg::status_t status;

  sexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (res.valid),
    .out_ready_i (res.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sexp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (req.req_type),
    .req_value_i  (req.req_value),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .reg_addr_o   (res.reg_addr),
    .reg_byte_o   (res.reg_byte),
    .status_bit_o (res.status),
    .last_o       (res.last)
  );

  // Accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while busy");

  // A rejected word is empty and is the final word of its request
  a_reject_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.status |-> res.last && res.reg_addr == '0 && res.reg_byte == '0)
    else $error("malformed reject word");

  // Multiplier and divider never finish together
  a_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.mul_done && status.div_done))
    else $error("arithmetic units overlap");

endmodule

>>> dv/sexp_checker.sv
// ----------------------------------------------------------------------------
// Sensor exposure timing control checker
// Watches the request, result and register write ports, predicts the
// register byte writes of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module sexp_checker
  import sexp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sexp_req_if                   req,
  sexp_res_if                   res,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    words_o
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              status;
    logic              last;
  } wr_word_t;

  // mirrored settings and sensor state
  logic [31:0]      pclk_hz;
  logic [15:0]      line_len;
  logic [19:0]      rate_scl;
  logic [19:0]      exp_scl;
  logic [19:0]      gain_scl;
  logic [VAL_W-1:0] gain_lo;
  logic [VAL_W-1:0] gain_hi;
  logic [19:0]      frame_lines;
  logic [VAL_W-1:0] last_expo;

  wr_word_t sensor_writes[$];

  assign pending_o = sensor_writes.size();

  function automatic void push_word(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                                    logic status);
    wr_word_t w;
    w.addr   = addr;
    w.data   = data;
    w.status = status;
    w.last   = 1'b0;
    sensor_writes.push_back(w);
  endfunction

  function automatic void push_value(logic [ADDR_W-1:0] addr, logic [23:0] val, int nbytes);
    for (int i = 0; i < nbytes; i++) push_word(addr + ADDR_W'(i), val[8*i +: 8], 1'b0);
  endfunction

  // shutter register from an exposure value; saturate the line quotient at 32 bits
  function automatic void shutter_writes(logic [VAL_W-1:0] v);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [63:0]  lines;
    logic [63:0]  maxl;
    if (pclk_hz == 0 || exp_scl == 0 || line_len == 0) begin
      push_word('0, '0, 1'b1);
      return;
    end
    prod  = 128'(v) * 128'(pclk_hz);
    quo   = prod / (128'(exp_scl) * 128'(line_len));
    lines = (quo > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : quo[63:0];
    maxl  = 64'(frame_lines) - 64'(MIN_SHUTTER);
    if (lines < 64'(MIN_LINES)) lines = 64'(MIN_LINES);
    else if (lines > maxl)      lines = maxl;
    push_value(ADDR_SHUTTER, 24'(64'(frame_lines) - lines), 3);
    last_expo = v;
  endfunction

  function automatic void predict_writes(op_e op, logic [VAL_W-1:0] v);
    int          first;
    logic [63:0] g;
    logic [63:0] f;
    first = sensor_writes.size();
    case (op)
      OP_GAIN: begin
        if (gain_scl == 0) begin
          push_word('0, '0, 1'b1);
        end else begin
          if (v < gain_lo)      v = gain_lo;
          else if (v > gain_hi) v = gain_hi;
          g = (64'(v) * 64'(GAIN_MAX)) / (64'(GAIN_DB) * 64'(gain_scl));
          if (g > 64'(GAIN_MAX)) g = 64'(GAIN_MAX);
          push_value(ADDR_GAIN, 24'(g), 2);
        end
      end
      OP_EXPO: shutter_writes(v);
      OP_FRAME: begin
        if (v == 0 || line_len == 0) begin
          push_word('0, '0, 1'b1);
        end else begin
          f = (64'(pclk_hz) * 64'(rate_scl)) / 64'(line_len) / 64'(v);
          if (f < 64'(MIN_FRAME))      f = 64'(MIN_FRAME);
          else if (f > 64'(MAX_FRAME)) f = 64'(MAX_FRAME);
          push_value(ADDR_FRAME, 24'(f), 3);
          frame_lines = f[19:0];
          if (last_expo != 0) shutter_writes(last_expo);
        end
      end
      default: push_word(ADDR_HOLD, (v != 0) ? 8'd1 : 8'd0, 1'b0);
    endcase
    if (sensor_writes.size() > first) sensor_writes[sensor_writes.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wr_word_t exp_w;
    int       nerr;
    nerr = 0;
    if (!rst_ni) begin
      pclk_hz     <= '0;
      line_len    <= '0;
      rate_scl    <= 20'd1000000;
      exp_scl     <= 20'd1000000;
      gain_scl    <= 20'd1;
      gain_lo     <= '0;
      gain_hi     <= 40'd30;
      frame_lines <= MIN_FRAME;
      last_expo   <= '0;
      errors_o    <= 0;
      words_o     <= 0;
      sensor_writes.delete();
    end else begin
      // compare each accepted word with the oldest expectation
      if (res.valid && res.ready) begin
        words_o <= words_o + 1;
        if (sensor_writes.size() == 0) begin
          $error("unexpected write word addr=%h byte=%h", res.reg_addr, res.reg_byte);
          nerr++;
        end else begin
          exp_w = sensor_writes.pop_front();
          if (res.reg_addr !== exp_w.addr) begin
            $error("reg_addr expected %h actual %h", exp_w.addr, res.reg_addr);
            nerr++;
          end
          if (res.reg_byte !== exp_w.data) begin
            $error("reg_byte expected %h actual %h", exp_w.data, res.reg_byte);
            nerr++;
          end
          if (res.status !== exp_w.status) begin
            $error("status expected %b actual %b", exp_w.status, res.status);
            nerr++;
          end
          if (res.last !== exp_w.last) begin
            $error("last expected %b actual %b", exp_w.last, res.last);
            nerr++;
          end
        end
        if (nerr != 0) errors_o <= errors_o + nerr;
      end
      // predict from the settings held before this edge
      if (req.valid && req.ready) predict_writes(op_e'(req.req_type), req.req_value);
      // mirror register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PCLK:       pclk_hz  <= cfg_data_i[31:0];
          CFG_LINE_LEN:   line_len <= cfg_data_i[15:0];
          CFG_RATE_SCALE: rate_scl <= cfg_data_i[19:0];
          CFG_EXP_SCALE:  exp_scl  <= cfg_data_i[19:0];
          CFG_GAIN_SCALE: gain_scl <= cfg_data_i[19:0];
          CFG_GAIN_FLOOR: gain_lo  <= cfg_data_i;
          CFG_GAIN_CEIL:  gain_hi  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> dv/tb_sensor_exposure_timing_control.sv
// ----------------------------------------------------------------------------
// Sensor exposure timing control testbench
// Directed corner requests, then random request phases under several register
// settings with bursty requests and a stalling write sink; checking is done
// by the checker module beside the block.
// ----------------------------------------------------------------------------
module tb_sensor_exposure_timing_control;
  import sexp_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    errors;
  int                    pending;
  int                    words;
  int                    requests;
  int                    idle_cycles;
  bit                    long_hold;

  sexp_req_if req ();
  sexp_res_if res ();

  sensor_exposure_timing_control dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req.sink),
    .res        (res.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  sexp_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .res        (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .errors_o   (errors),
    .pending_o  (pending),
    .words_o    (words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // write sink: stall pattern changes at random, one long hold on request
  initial begin
    int mode;
    res.ready = 1'b0;
    mode      = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        if ($urandom_range(63) == 0) mode = $urandom_range(2);
        case (mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= ($urandom_range(1) == 1);
          default: res.ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (res.valid && res.ready) || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // offer one request and hold it until accepted
  task automatic send_req(op_e op, logic [VAL_W-1:0] v);
    req.valid     <= 1'b1;
    req.req_type  <= op;
    req.req_value <= v;
    do @(negedge clk_i); while (!req.ready);
    @(posedge clk_i);
    requests++;
  endtask

  task automatic drop_valid(int gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every expected word has come, then let the block settle
  task automatic drain();
    drop_valid(1);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] pclk, logic [15:0] line, logic [19:0] rate,
                            logic [19:0] expo, logic [19:0] gscl, logic [VAL_W-1:0] glo,
                            logic [VAL_W-1:0] ghi);
    logic [CFG_DATA_W-1:0] vals[7];
    vals = '{40'(pclk), 40'(line), 40'(rate), 40'(expo), 40'(gscl), glo, ghi};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(4))
      0:       return {8'($urandom_range(255)), $urandom()};
      1:       return 40'($urandom_range(200));
      2:       return 40'($urandom_range(32'h00FF_FFFF));
      3:       return 40'($urandom_range(2000000));
      default: return 40'($urandom_range(100000));
    endcase
  endfunction

  // random bursts with random gaps
  task automatic random_phase(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(8, 1);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_req(op_e'($urandom_range(3)), rand_value());
        left--;
      end
      drop_valid(($urandom_range(2) == 0) ? 0 : $urandom_range(6));
    end
  endtask

  initial begin
    requests      = 0;
    long_hold     = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PCLK;
    cfg_data_i    = '0;
    req.valid     = 1'b0;
    req.req_type  = OP_GAIN;
    req.req_value = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: gain limits, group hold, rejected frame rate and exposure
    send_req(OP_GAIN, '0);
    send_req(OP_GAIN, '1);
    send_req(OP_GAIN, 40'd15);
    send_req(OP_HOLD, '0);
    send_req(OP_HOLD, '1);
    send_req(OP_HOLD, 40'd1);
    send_req(OP_FRAME, '0);
    send_req(OP_FRAME, 40'd5);
    send_req(OP_EXPO, 40'd1000);
    drain();

    // typical sensor mode: clamps, saturating exposure, re-derive on frame rate
    write_regs(32'd74250000, 16'd4400, 20'd1000000, 20'd1000000, 20'd1, 40'd0, 40'd300);
    send_req(OP_EXPO, '0);
    send_req(OP_EXPO, '1);
    send_req(OP_EXPO, 40'd10000);
    send_req(OP_FRAME, 40'd1);
    send_req(OP_EXPO, 40'd33000);
    send_req(OP_FRAME, '1);
    send_req(OP_FRAME, 40'd30000000);
    send_req(OP_GAIN, 40'd299);
    send_req(OP_GAIN, '1);
    drain();

    // inverted gain limits, zero pixel clock, exposure re-derive rejected
    write_regs(32'd0, 16'd1, 20'd1, 20'd0, 20'd1, 40'd10, 40'd5);
    send_req(OP_GAIN, 40'd0);
    send_req(OP_GAIN, 40'd7);
    send_req(OP_GAIN, '1);
    send_req(OP_FRAME, 40'd3);
    send_req(OP_EXPO, 40'd55);
    drain();

    // zero gain divisor
    write_regs(32'd1, 16'd1, 20'd1, 20'd1, 20'd0, 40'd0, '1);
    send_req(OP_GAIN, 40'd77);
    send_req(OP_FRAME, 40'd1);
    drain();

    // largest settings, with one long sink hold while requests keep coming
    write_regs('1, '1, 20'd1000000, 20'd1000000, 20'd1000000, '0, '1);
    long_hold = 1'b1;
    random_phase(65);
    drain();

    // smallest nonzero settings
    write_regs(32'd1, 16'd1, 20'd1, 20'd1, 20'd1, 40'd0, 40'd1000);
    random_phase(65);
    drain();

    // random settings
    for (int p = 0; p < 4; p++) begin
      write_regs($urandom(), 16'($urandom_range(16'hFFFF, 1)), 20'($urandom_range(1000000)),
                 20'($urandom_range(1000000, 1)), 20'($urandom_range(1000)),
                 40'($urandom_range(50)), {8'($urandom_range(255)), $urandom()});
      random_phase(65);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests giving %0d register writes over ten settings,", requests, words);
    $display("including clamps, rejects, saturation, re-derive and back-pressure.");
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
